FILE: hdl/xesc_pkg.sv
`default_nettype none
package xesc_pkg;

    // Kinds of work handed from the front to the back
    localparam logic [1:0] K_BYTE = 2'd0;
    localparam logic [1:0] K_END  = 2'd1;
    localparam logic [1:0] K_ENT  = 2'd2;

    // Entity codes
    localparam logic [2:0] E_LT   = 3'd0;
    localparam logic [2:0] E_GT   = 3'd1;
    localparam logic [2:0] E_AMP  = 3'd2;
    localparam logic [2:0] E_APOS = 3'd3;
    localparam logic [2:0] E_QUOT = 3'd4;

    // Character codes
    localparam logic [7:0] C_TAB   = 8'h09;
    localparam logic [7:0] C_LF    = 8'h0A;
    localparam logic [7:0] C_VT    = 8'h0B;
    localparam logic [7:0] C_FF    = 8'h0C;
    localparam logic [7:0] C_CR    = 8'h0D;
    localparam logic [7:0] C_BS    = 8'h08;
    localparam logic [7:0] C_ESC   = 8'h1B;
    localparam logic [7:0] C_SPACE = 8'h20;
    localparam logic [7:0] C_QUOT  = 8'h22;
    localparam logic [7:0] C_AMP   = 8'h26;
    localparam logic [7:0] C_APOS  = 8'h27;
    localparam logic [7:0] C_SEMI  = 8'h3B;
    localparam logic [7:0] C_LT    = 8'h3C;
    localparam logic [7:0] C_GT    = 8'h3E;
    localparam logic [7:0] C_A     = 8'h61;
    localparam logic [7:0] C_G     = 8'h67;
    localparam logic [7:0] C_L     = 8'h6C;
    localparam logic [7:0] C_M     = 8'h6D;
    localparam logic [7:0] C_O     = 8'h6F;
    localparam logic [7:0] C_P     = 8'h70;
    localparam logic [7:0] C_Q     = 8'h71;
    localparam logic [7:0] C_S     = 8'h73;
    localparam logic [7:0] C_T     = 8'h74;
    localparam logic [7:0] C_U     = 8'h75;

    // One classified request: a plain byte, an entity code or an end marker
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
    } t_op;

    // Index of the last character of an entity
    function automatic logic [2:0] ent_last(input logic [2:0] code);
        logic [2:0] r;
        case (code)
            E_LT, E_GT:     r = 3'd3;
            E_AMP:          r = 3'd4;
            default:        r = 3'd5;
        endcase
        return r;
    endfunction

    // Character of an entity at a position
    function automatic logic [7:0] ent_byte(input logic [2:0] code, input logic [2:0] idx);
        logic [7:0] r;
        r = C_SEMI;
        if (idx == 3'd0) begin
            r = C_AMP;
        end else if (idx == ent_last(code)) begin
            r = C_SEMI;
        end else begin
            case (code)
                E_LT:    r = (idx == 3'd1) ? C_L : C_T;
                E_GT:    r = (idx == 3'd1) ? C_G : C_T;
                E_AMP:   r = (idx == 3'd1) ? C_A : ((idx == 3'd2) ? C_M : C_P);
                E_APOS: begin
                    case (idx)
                        3'd1:    r = C_A;
                        3'd2:    r = C_P;
                        3'd3:    r = C_O;
                        default: r = C_S;
                    endcase
                end
                default: begin
                    case (idx)
                        3'd1:    r = C_Q;
                        3'd2:    r = C_U;
                        3'd3:    r = C_O;
                        default: r = C_T;
                    endcase
                end
            endcase
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/xml_escape_whitespace_collapse_unit.sv
// XML text escaper with whitespace collapsing.
// Input stream: one byte of text per request on s_axis_tdata, or an end of
// string marker with s_axis_tlast high (tdata then ignored). Output stream:
// one byte per request on m_axis_tdata; m_axis_tlast marks the last byte
// produced by one input request, m_axis_tuser marks the end of string
// result (tdata zero). Leading whitespace, CR, FF, BS and ESC give no
// output; blank runs give one space; the five XML specials expand to
// entities of 4 to 6 bytes.
// A request accepted by the front is written into the queue, then loaded
// from the queue head into the output register, from which its first byte
// is taken.
// Throughput: one input per cycle while each gives at most one byte and
// m_axis_tready is high; the back end emits entities one byte per cycle
// as the front goes on filling the queue. The queue (QUEUE_DEPTH entries)
// absorbs short bursts, and s_axis_tready falls only when it is full. A
// stall on m_axis_tready holds the output register and fills the queue.
// Reset empties the queue and the output register and returns the
// string state to "at start of string".
`default_nettype none
module xml_escape_whitespace_collapse_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_byte
    input  wire logic        s_axis_tlast,   // string_end
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
    output logic             m_axis_tlast,   // run_last
    output logic             m_axis_tuser    // end_mark
);
    import xesc_pkg::*;

    t_op  w_op, w_head;
    logic w_push, w_pop, w_nonempty, w_full;

    assign s_axis_tready = !w_full;

    xesc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_char   (s_axis_tdata),
        .i_end    (s_axis_tlast),
        .i_accept (s_axis_tready),
        .o_op     (w_op),
        .o_push   (w_push)
    );

    xesc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_op       (w_op),
        .i_pop      (w_pop),
        .o_head     (w_head),
        .o_nonempty (w_nonempty),
        .o_full     (w_full)
    );

    xesc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .i_nonempty (w_nonempty),
        .o_pop      (w_pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_byte     (m_axis_tdata),
        .o_last     (m_axis_tlast),
        .o_end      (m_axis_tuser)
    );

endmodule
`default_nettype wire

FILE: hdl/xesc_front.sv
`default_nettype none
module xesc_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [7:0]    i_char,
    input  wire logic          i_end,
    input  wire logic          i_accept,
    output xesc_pkg::t_op      o_op,
    output logic               o_push
);
    import xesc_pkg::*;

    logic r_start, n_start;
    logic r_run,   n_run;

    // Classify the byte and advance the string state
    always_comb begin
        n_start = r_start;
        n_run   = r_run;
        o_op    = '{kind: K_BYTE, data: i_char};
        o_push  = 1'b0;
        if (i_end) begin
            n_start = 1'b1;
            n_run   = 1'b0;
            o_op    = '{kind: K_END, data: 8'h00};
            o_push  = 1'b1;
        end else if (r_start && (i_char == C_SPACE || (i_char >= C_TAB && i_char <= C_CR))) begin
            // drop leading whitespace
            o_push = 1'b0;
        end else begin
            n_start = 1'b0;
            unique case (i_char) inside
                C_LT: begin
                    n_run = 1'b0; o_push = 1'b1; o_op = '{kind: K_ENT, data: {5'd0, E_LT}};
                end
                C_GT: begin
                    n_run = 1'b0; o_push = 1'b1; o_op = '{kind: K_ENT, data: {5'd0, E_GT}};
                end
                C_AMP: begin
                    n_run = 1'b0; o_push = 1'b1; o_op = '{kind: K_ENT, data: {5'd0, E_AMP}};
                end
                C_APOS: begin
                    n_run = 1'b0; o_push = 1'b1; o_op = '{kind: K_ENT, data: {5'd0, E_APOS}};
                end
                C_QUOT: begin
                    n_run = 1'b0; o_push = 1'b1; o_op = '{kind: K_ENT, data: {5'd0, E_QUOT}};
                end
                C_CR, C_FF, C_BS, C_ESC: begin
                    o_push = 1'b0;
                end
                C_SPACE, C_TAB, C_LF: begin
                    // one space per blank run
                    o_push = !r_run;
                    n_run  = 1'b1;
                    o_op   = '{kind: K_BYTE, data: C_SPACE};
                end
                default: begin
                    n_run  = 1'b0;
                    o_push = 1'b1;
                end
            endcase
        end
        o_push = o_push && i_valid && i_accept;
    end

    // Hold string state; update on accepted requests
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= 1'b1;
            r_run   <= 1'b0;
        end else if (i_valid && i_accept) begin
            r_start <= n_start;
            r_run   <= n_run;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/xesc_queue.sv
`default_nettype none
module xesc_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire xesc_pkg::t_op i_op,
    input  wire logic          i_pop,
    output xesc_pkg::t_op      o_head,
    output logic               o_nonempty,
    output logic               o_full
);
    import xesc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_MAX = PW'(DEPTH - 1);

    t_op            r_mem [DEPTH];
    logic [PW-1:0]  r_wr, r_rd;
    logic [CW-1:0]  r_cnt;
    logic           w_push, w_pop;

    assign o_nonempty = (r_cnt != '0);
    assign o_full     = (r_cnt == CW'(DEPTH));
    assign o_head     = r_mem[r_rd];
    assign w_push     = i_push && !o_full;
    assign w_pop      = i_pop && o_nonempty;

    // Store entries
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_op;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_MAX) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_MAX) ? '0 : r_rd + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: hdl/xesc_back.sv
`default_nettype none
module xesc_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire xesc_pkg::t_op i_head,
    input  wire logic          i_nonempty,
    output logic               o_pop,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [7:0]         o_byte,
    output logic               o_last,
    output logic               o_end
);
    import xesc_pkg::*;

    logic       r_valid;
    logic [2:0] r_idx;
    logic [7:0] r_byte, n_byte;
    logic       r_last, n_last;
    logic       r_end,  n_end;
    logic       w_load;

    // Pick the next result byte from the queue head
    always_comb begin
        n_byte = i_head.data;
        n_last = 1'b1;
        n_end  = 1'b0;
        case (i_head.kind)
            K_END: begin
                n_byte = 8'h00;
                n_end  = 1'b1;
            end
            K_ENT: begin
                n_byte = ent_byte(i_head.data[2:0], r_idx);
                n_last = (r_idx == ent_last(i_head.data[2:0]));
            end
            default: begin
                n_byte = i_head.data;
            end
        endcase
    end

    assign w_load  = i_nonempty && (!r_valid || i_ready);
    assign o_pop   = w_load && n_last;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_last  = r_last;
    assign o_end   = r_end;

    // Hold output until taken; step through entity characters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_idx   <= n_last ? 3'd0 : r_idx + 3'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= n_byte;
            r_last <= n_last;
            r_end  <= n_end;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/xesc_checker.sv
`default_nettype none
module xesc_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       s_axis_tvalid,
    input wire logic       s_axis_tready,
    input wire logic [7:0] s_axis_tdata,
    input wire logic       s_axis_tlast,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic       m_axis_tlast,
    input wire logic       m_axis_tuser
);

    // Reset empties the output
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // Waiting input request holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid
            && $stable(s_axis_tdata) && $stable(s_axis_tlast))
        else $error("waiting input changed");

    // Stalled output holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid
            && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("stalled output changed");

    // End marker is a single zero result
    a_end_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == 8'h00))
        else $error("malformed end marker");

    // An entity continues without a gap
    a_ent_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
        else $error("entity bytes interrupted");

endmodule

bind xml_escape_whitespace_collapse_unit xesc_checker u_chk (.*);
`default_nettype wire
